// ===== rtl/core/bssm_pkg.sv =====
// Shared types and constants of the bilateral sample sync matcher.
// No dependencies; imported by the channel interfaces and the top level.
package bssm_pkg;

    localparam int TAG_BITS   = 8;
    localparam int TIME_BITS  = 32;
    localparam int LIMIT_BITS = 10;
    localparam int QUAL_BITS  = 7;
    localparam int CNT_BITS   = 32;
    localparam int CFG_IDX_BITS = 2;

    typedef logic [TAG_BITS-1:0]   tag_t;
    typedef logic [TIME_BITS-1:0]  stamp_t;
    typedef logic [LIMIT_BITS-1:0] limit_t;
    typedef logic [QUAL_BITS-1:0]  qual_t;
    typedef logic [CNT_BITS-1:0]   count_t;
    typedef logic [CFG_IDX_BITS-1:0] cfg_idx_t;

    localparam cfg_idx_t CFG_EXCELLENT = 2'd0;
    localparam cfg_idx_t CFG_GOOD      = 2'd1;
    localparam cfg_idx_t CFG_FAIR      = 2'd2;
    localparam cfg_idx_t CFG_TIMEOUT   = 2'd3;

    localparam limit_t EXCELLENT_RST = 10'd5;
    localparam limit_t GOOD_RST      = 10'd10;
    localparam limit_t FAIR_RST      = 10'd20;
    localparam limit_t TIMEOUT_RST   = 10'd50;

    localparam qual_t QUAL_EXCELLENT = 7'd100;
    localparam qual_t QUAL_GOOD      = 7'd80;
    localparam qual_t QUAL_FAIR      = 7'd60;
    localparam qual_t QUAL_POOR      = 7'd40;
    localparam qual_t QUAL_NONE      = 7'd0;

    localparam logic KIND_FOOT = 1'b0;
    localparam logic KIND_IMU  = 1'b1;

endpackage

// ===== rtl/core/bssm_ifs.sv =====
// Valid/ready channel interfaces for sample arrivals and match results.
// Depends on bssm_pkg.
interface bssm_sample_if;
    import bssm_pkg::*;

    logic   valid;
    logic   ready;
    logic   req_type;
    logic   is_left;
    stamp_t arrival_time;
    tag_t   payload_tag;

    modport source (output valid, req_type, is_left, arrival_time, payload_tag,
                    input ready);
    modport sink   (input valid, req_type, is_left, arrival_time, payload_tag,
                    output ready);
endinterface

interface bssm_match_if;
    import bssm_pkg::*;

    logic   valid;
    logic   ready;
    logic   match_valid;
    stamp_t match_time;
    qual_t  quality;
    tag_t   left_foot_tag;
    tag_t   right_foot_tag;
    logic   left_imu_valid;
    tag_t   left_imu_tag;
    logic   right_imu_valid;
    tag_t   right_imu_tag;
    count_t full_matches;
    count_t partial_matches;
    count_t timeout_drops;

    modport source (output valid, match_valid, match_time, quality, left_foot_tag,
                    right_foot_tag, left_imu_valid, left_imu_tag, right_imu_valid,
                    right_imu_tag, full_matches, partial_matches, timeout_drops,
                    input ready);
    modport sink   (input valid, match_valid, match_time, quality, left_foot_tag,
                    right_foot_tag, left_imu_valid, left_imu_tag, right_imu_valid,
                    right_imu_tag, full_matches, partial_matches, timeout_drops,
                    output ready);
endinterface

// ===== rtl/core/bilateral_sample_sync_matcher.sv =====
// Top level of the bilateral sample sync matcher: pairs left and right foot samples.
// Depends on bssm_pkg and the channel interfaces in bssm_ifs.sv.
//
// Usage:
//   sample_chan carries one transaction per sample arrival (foot or IMU, left or
//   right, arrival time, payload tag). match_chan returns exactly one transaction
//   per sample: a match record when both feet pair within the timeout, otherwise
//   match_valid low; the three wrapping counters ride along on every transaction.
//   cfg_we/cfg_index/cfg_data write the four grading limits; write them only
//   while no transaction is in flight.
//   The input register loads on sample acceptance and the result register loads
//   from it when the result register is free or being read. Throughput: one
//   transaction per cycle while the receiver does not stall; the whole decision
//   is a stamp difference and limit compares between the two registers.
//   When the receiver stalls, the result register holds and the input register,
//   if empty, takes one more sample; ready then drops until the result is taken.
//   Reset clears all pending flags, stored stamps and tags, the counters and
//   the pipeline valid bits, and loads the default limits 5, 10, 20 and 50 ms.
module bilateral_sample_sync_matcher (
    input  logic                clk,
    input  logic                rst_n,
    bssm_sample_if.sink         sample_chan,
    bssm_match_if.source        match_chan,
    input  logic                cfg_we,
    input  bssm_pkg::cfg_idx_t  cfg_index,
    input  bssm_pkg::limit_t    cfg_data
);
    import bssm_pkg::*;

    limit_t excellent_reg, good_reg, fair_reg, timeout_reg;

    logic   in_valid_reg;
    logic   in_kind_reg;
    logic   in_left_reg;
    stamp_t in_time_reg;
    tag_t   in_tag_reg;

    logic   rfp_reg, lfp_reg, rip_reg, lip_reg;
    stamp_t rstamp_reg, lstamp_reg;
    tag_t   rfslot_reg, lfslot_reg, rislot_reg, lislot_reg;
    count_t full_reg, partial_reg, timeout_cnt_reg;

    logic   out_valid_reg;
    logic   match_valid_reg;
    stamp_t match_time_reg;
    qual_t  quality_reg;
    tag_t   left_foot_tag_reg, right_foot_tag_reg;
    logic   left_imu_valid_reg, right_imu_valid_reg;
    tag_t   left_imu_tag_reg, right_imu_tag_reg;

    logic   advance;
    logic   take;
    logic   rfp_next, lfp_next, rip_next, lip_next;
    stamp_t rstamp_next, lstamp_next;
    tag_t   rfslot_next, lfslot_next, rislot_next, lislot_next;
    count_t full_next, partial_next, timeout_cnt_next;
    logic   both_feet, r_later, r_earlier, too_far, is_match;
    stamp_t diff, later;
    qual_t  grade;

    assign advance = !out_valid_reg || match_chan.ready;
    assign sample_chan.ready = !in_valid_reg || advance;
    assign take = in_valid_reg && advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            excellent_reg <= EXCELLENT_RST;
            good_reg      <= GOOD_RST;
            fair_reg      <= FAIR_RST;
            timeout_reg   <= TIMEOUT_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_EXCELLENT: excellent_reg <= cfg_data;
                CFG_GOOD:      good_reg      <= cfg_data;
                CFG_FAIR:      fair_reg      <= cfg_data;
                CFG_TIMEOUT:   timeout_reg   <= cfg_data;
                default:       excellent_reg <= excellent_reg;
            endcase
        end
    end

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (sample_chan.ready)
            in_valid_reg <= sample_chan.valid;
    end

    always_ff @(posedge clk)
    begin
        if (sample_chan.ready && sample_chan.valid)
        begin
            in_kind_reg <= sample_chan.req_type;
            in_left_reg <= sample_chan.is_left;
            in_time_reg <= sample_chan.arrival_time;
            in_tag_reg  <= sample_chan.payload_tag;
        end
    end

    // Decision logic
    always_comb
    begin
        rfp_next    = rfp_reg;
        lfp_next    = lfp_reg;
        rip_next    = rip_reg;
        lip_next    = lip_reg;
        rstamp_next = rstamp_reg;
        lstamp_next = lstamp_reg;
        rfslot_next = rfslot_reg;
        lfslot_next = lfslot_reg;
        rislot_next = rislot_reg;
        lislot_next = lislot_reg;

        if (in_kind_reg == KIND_IMU)
        begin
            if (in_left_reg)
            begin
                lislot_next = in_tag_reg;
                lip_next    = 1'b1;
            end
            else
            begin
                rislot_next = in_tag_reg;
                rip_next    = 1'b1;
            end
        end
        else
        begin
            if (in_left_reg)
            begin
                lfslot_next = in_tag_reg;
                lstamp_next = in_time_reg;
                lfp_next    = 1'b1;
            end
            else
            begin
                rfslot_next = in_tag_reg;
                rstamp_next = in_time_reg;
                rfp_next    = 1'b1;
            end
        end

        both_feet = rfp_next && lfp_next;
        r_later   = rstamp_next > lstamp_next;
        r_earlier = rstamp_next < lstamp_next;
        diff      = r_later ? (rstamp_next - lstamp_next) : (lstamp_next - rstamp_next);
        later     = r_later ? rstamp_next : lstamp_next;
        too_far   = diff > stamp_t'(timeout_reg);
        is_match  = both_feet && !too_far;

        priority if (diff <= stamp_t'(excellent_reg))
            grade = QUAL_EXCELLENT;
        else if (diff <= stamp_t'(good_reg))
            grade = QUAL_GOOD;
        else if (diff <= stamp_t'(fair_reg))
            grade = QUAL_FAIR;
        else if (diff <= stamp_t'(timeout_reg))
            grade = QUAL_POOR;
        else
            grade = QUAL_NONE;

        full_next        = full_reg;
        partial_next     = partial_reg;
        timeout_cnt_next = timeout_cnt_reg;

        if (both_feet && too_far)
        begin
            if (r_earlier)
                rfp_next = 1'b0;
            else
                lfp_next = 1'b0;
            timeout_cnt_next = timeout_cnt_reg + count_t'(1);
        end
        else if (is_match)
        begin
            if (lip_next && rip_next)
                full_next = full_reg + count_t'(1);
            else
                partial_next = partial_reg + count_t'(1);
            rfp_next = 1'b0;
            lfp_next = 1'b0;
            rip_next = 1'b0;
            lip_next = 1'b0;
        end
    end

    // Matcher state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rfp_reg         <= 1'b0;
            lfp_reg         <= 1'b0;
            rip_reg         <= 1'b0;
            lip_reg         <= 1'b0;
            rstamp_reg      <= '0;
            lstamp_reg      <= '0;
            rfslot_reg      <= '0;
            lfslot_reg      <= '0;
            rislot_reg      <= '0;
            lislot_reg      <= '0;
            full_reg        <= '0;
            partial_reg     <= '0;
            timeout_cnt_reg <= '0;
        end
        else if (take)
        begin
            rfp_reg         <= rfp_next;
            lfp_reg         <= lfp_next;
            rip_reg         <= rip_next;
            lip_reg         <= lip_next;
            rstamp_reg      <= rstamp_next;
            lstamp_reg      <= lstamp_next;
            rfslot_reg      <= rfslot_next;
            lfslot_reg      <= lfslot_next;
            rislot_reg      <= rislot_next;
            lislot_reg      <= lislot_next;
            full_reg        <= full_next;
            partial_reg     <= partial_next;
            timeout_cnt_reg <= timeout_cnt_next;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= in_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            match_valid_reg     <= is_match;
            match_time_reg      <= is_match ? later : '0;
            quality_reg         <= is_match ? grade : QUAL_NONE;
            left_foot_tag_reg   <= is_match ? lfslot_next : '0;
            right_foot_tag_reg  <= is_match ? rfslot_next : '0;
            left_imu_valid_reg  <= is_match && lip_reg | (is_match && in_kind_reg
                                   == KIND_IMU && in_left_reg);
            left_imu_tag_reg    <= (is_match && (lip_reg || (in_kind_reg == KIND_IMU
                                   && in_left_reg))) ? lislot_next : '0;
            right_imu_valid_reg <= is_match && rip_reg | (is_match && in_kind_reg
                                   == KIND_IMU && !in_left_reg);
            right_imu_tag_reg   <= (is_match && (rip_reg || (in_kind_reg == KIND_IMU
                                   && !in_left_reg))) ? rislot_next : '0;
        end
    end

    assign match_chan.valid           = out_valid_reg;
    assign match_chan.match_valid     = match_valid_reg;
    assign match_chan.match_time      = match_time_reg;
    assign match_chan.quality         = quality_reg;
    assign match_chan.left_foot_tag   = left_foot_tag_reg;
    assign match_chan.right_foot_tag  = right_foot_tag_reg;
    assign match_chan.left_imu_valid  = left_imu_valid_reg;
    assign match_chan.left_imu_tag    = left_imu_tag_reg;
    assign match_chan.right_imu_valid = right_imu_valid_reg;
    assign match_chan.right_imu_tag   = right_imu_tag_reg;
    assign match_chan.full_matches    = full_reg;
    assign match_chan.partial_matches = partial_reg;
    assign match_chan.timeout_drops   = timeout_cnt_reg;

    a_match_graded: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && match_valid_reg) |-> (quality_reg != QUAL_NONE))
        else $error("match result carries no quality grade");

    a_no_match_no_imu: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !match_valid_reg) |-> (!left_imu_valid_reg && !right_imu_valid_reg))
        else $error("IMU record reported without a match");

    a_match_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (take && is_match) |=> (!rfp_reg && !lfp_reg && !rip_reg && !lip_reg))
        else $error("pending flags left set after a match");

    a_one_count: assert property (@(posedge clk) disable iff (!rst_n)
        take |=> ($countones({full_reg != $past(full_reg),
                              partial_reg != $past(partial_reg),
                              timeout_cnt_reg != $past(timeout_cnt_reg)}) <= 1))
        else $error("more than one counter advanced for one transaction");

endmodule
